[src/multiply_accumulate_long_unit_core_assert.svh]
// assertion macros for the multiply accumulate unit checks
`ifndef MULTIPLY_ACCUMULATE_LONG_UNIT_CORE_ASSERT_SVH
`define MULTIPLY_ACCUMULATE_LONG_UNIT_CORE_ASSERT_SVH

// property that must hold at every clock edge outside reset
`define MALU_ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("malu check failed");

// consequent must hold in the same cycle as the antecedent
`define MALU_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("malu check failed");

`endif

[src/malu_pkg.sv]
// types shared by the multiply accumulate unit modules
package malu_pkg;

   typedef struct packed {
      logic [31:0] operand_m;
      logic [31:0] operand_s;
      logic [31:0] acc_high;
      logic [31:0] acc_low;
      logic        long_form;
      logic        signed_form;
      logic        accumulate;
      logic        set_flags;
   } req_type;

   typedef struct packed {
      logic [31:0] result_low;
      logic [31:0] result_high;
      logic        high_written;
      logic        negative_flag;
      logic        zero_flag;
      logic        flags_update;
      logic        undefined;
   } rsp_type;

   typedef struct packed {
      logic valid;
      logic long_form;
      logic undefined;
      logic set_flags;
   } ctl_type;

endpackage

[src/malu_mul.sv]
// multiplier stages: partial products, then the 64-bit product with sign correction
module malu_mul (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  malu_pkg::req_type req,
   output malu_pkg::ctl_type ctl,
   output logic [63:0]       product,
   output logic [63:0]       addend
);
   import malu_pkg::*;

   logic          signed_mul;
   logic [47:0]   pp_lo_in, pp_lo_ff;
   logic [47:0]   pp_hi_in, pp_hi_ff;
   logic [31:0]   corr_in, corr_ff;
   logic [63:0]   acc_in, acc1_ff, acc2_ff;
   ctl_type       ctl1_in, ctl1_ff, ctl2_ff;
   logic [63:0]   product_in, product_ff;

   // stage one: two 32x16 partial products and the signed correction word
   assign signed_mul = req.signed_form & req.long_form;
   assign pp_lo_in   = 48'(req.operand_m) * 48'(req.operand_s[15:0]);
   assign pp_hi_in   = 48'(req.operand_m) * 48'(req.operand_s[31:16]);
   assign corr_in    = ((signed_mul & req.operand_m[31]) ? req.operand_s : 32'd0)
                     + ((signed_mul & req.operand_s[31]) ? req.operand_m : 32'd0);

   // accumulator operand, high word only in long form
   assign acc_in = req.accumulate
                 ? {(req.long_form ? req.acc_high : 32'd0), req.acc_low}
                 : 64'd0;

   always_comb begin
      ctl1_in.valid     = in_valid;
      ctl1_in.long_form = req.long_form;
      ctl1_in.undefined = ~req.long_form & req.signed_form;
      ctl1_in.set_flags = req.set_flags;
   end

   // stage two: assemble the product, subtract the sign correction in the high word
   assign product_in = {16'd0, pp_lo_ff} + {pp_hi_ff, 16'd0} - {corr_ff, 32'd0};

   // pipeline registers, only the valid bits are reset
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff.valid <= 1'b0;
         ctl2_ff.valid <= 1'b0;
      end else begin
         ctl1_ff.valid <= ctl1_in.valid;
         ctl2_ff.valid <= ctl1_ff.valid;
      end
      ctl1_ff.long_form <= ctl1_in.long_form;
      ctl1_ff.undefined <= ctl1_in.undefined;
      ctl1_ff.set_flags <= ctl1_in.set_flags;
      pp_lo_ff          <= pp_lo_in;
      pp_hi_ff          <= pp_hi_in;
      corr_ff           <= corr_in;
      acc1_ff           <= acc_in;
      ctl2_ff.long_form <= ctl1_ff.long_form;
      ctl2_ff.undefined <= ctl1_ff.undefined;
      ctl2_ff.set_flags <= ctl1_ff.set_flags;
      product_ff        <= product_in;
      acc2_ff           <= acc1_ff;
   end

   assign ctl     = ctl2_ff;
   assign product = product_ff;
   assign addend  = acc2_ff;

endmodule

[src/malu_fin.sv]
// final stage: accumulate add, result words, flags and the output register
module malu_fin (
   input  logic              clock,
   input  logic              reset,
   input  malu_pkg::ctl_type ctl,
   input  logic [63:0]       product,
   input  logic [63:0]       addend,
   output logic              rsp_strobe,
   output malu_pkg::rsp_type rsp_payload
);
   import malu_pkg::*;

   logic [63:0] sum;
   logic        strobe_in, strobe_ff;
   rsp_type     rsp_in, rsp_ff;

   assign sum = product + addend;

   // result formatting per form
   always_comb begin
      rsp_in = '0;
      if (ctl.undefined) begin
         rsp_in.undefined = 1'b1;
      end else if (ctl.long_form) begin
         rsp_in.result_low   = sum[31:0];
         rsp_in.result_high  = sum[63:32];
         rsp_in.high_written = 1'b1;
         if (ctl.set_flags) begin
            rsp_in.flags_update  = 1'b1;
            rsp_in.negative_flag = sum[63];
            rsp_in.zero_flag     = (sum == 64'd0);
         end
      end else begin
         rsp_in.result_low = sum[31:0];
         if (ctl.set_flags) begin
            rsp_in.flags_update  = 1'b1;
            rsp_in.negative_flag = sum[31];
            rsp_in.zero_flag     = (sum[31:0] == 32'd0);
         end
      end
   end

   assign strobe_in = ctl.valid;

   // output strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= strobe_in;
      end
   end

   // output payload
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe  = strobe_ff;
   assign rsp_payload = rsp_ff;

endmodule

[src/multiply_accumulate_long_unit_core.sv]
// Multiply accumulate unit, 32x32 operands with a 32-bit or 64-bit result.
// A request is taken on every clock edge where start is high and busy is low;
// busy is high only during reset, so a new request can enter every cycle.
// Each request gives one result, registered through the stage registers and the
// output register, shown with rsp_strobe for one cycle; the receiver cannot stall and must take it then.
// The three stages are the 32x16 partial products, the 64-bit product with
// signed correction, and the accumulate add with flag generation.
module multiply_accumulate_long_unit_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  malu_pkg::req_type req_payload,
   output logic              rsp_strobe,
   output malu_pkg::rsp_type rsp_payload
);
   import malu_pkg::*;

   ctl_type     mul_ctl;
   logic [63:0] mul_product;
   logic [63:0] mul_addend;
   logic        req_fire;

   // requests are held off only while reset is applied
   assign busy     = reset;
   assign req_fire = start & ~busy;

   malu_mul u_mul (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_fire),
      .req      (req_payload),
      .ctl      (mul_ctl),
      .product  (mul_product),
      .addend   (mul_addend)
   );

   malu_fin u_fin (
      .clock       (clock),
      .reset       (reset),
      .ctl         (mul_ctl),
      .product     (mul_product),
      .addend      (mul_addend),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

endmodule

[src/malu_checker.sv]
// port-level checks for the multiply accumulate unit, bound to the top level
`include "multiply_accumulate_long_unit_core_assert.svh"

module malu_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_strobe,
   input malu_pkg::rsp_type rsp_payload
);
   import malu_pkg::*;

   logic undef_quiet;
   logic neg_expected;

   // nothing written for an undefined encoding
   assign undef_quiet = (rsp_payload.result_low == 32'd0)
                      && (rsp_payload.result_high == 32'd0)
                      && !rsp_payload.high_written
                      && !rsp_payload.flags_update;

   // top bit of the long or short result
   assign neg_expected = rsp_payload.high_written ? rsp_payload.result_high[31]
                                                  : rsp_payload.result_low[31];

   // every request gives one result, and no other
   `MALU_ASSERT_ALWAYS(a_latency, clock, reset, rsp_strobe == $past(start && !busy, 3))

   // undefined encoding writes nothing
   `MALU_ASSERT_IMPLIES(a_undef_quiet, clock, reset, rsp_strobe && rsp_payload.undefined, undef_quiet)

   // short form leaves the high word clear
   `MALU_ASSERT_IMPLIES(a_short_high, clock, reset, rsp_strobe && !rsp_payload.high_written, rsp_payload.result_high == 32'd0)

   // negative flag follows the top bit of the result
   `MALU_ASSERT_IMPLIES(a_neg_flag, clock, reset, rsp_strobe && rsp_payload.flags_update, rsp_payload.negative_flag == neg_expected)

endmodule

bind multiply_accumulate_long_unit_core malu_checker u_malu_checker (.*);

[dv/multiply_accumulate_long_unit_core_tb.sv]
`timescale 1ns / 1ps
// self-checking testbench for the multiply accumulate long unit core
module multiply_accumulate_long_unit_core_tb;
   import malu_pkg::*;

   localparam logic [31:0] ALL_ONES    = 32'hFFFF_FFFF;
   localparam logic [31:0] MOST_NEG    = 32'h8000_0000;
   localparam logic [31:0] MOST_POS    = 32'h7FFF_FFFF;
   localparam int          DRAIN_LIMIT = 200;
   localparam int          SETTLE_CYCLES = 8;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_payload = '0;
   logic    rsp_strobe;
   rsp_type rsp_payload;

   // products still in flight through the pipeline, oldest first
   rsp_type pending_products[$];
   int      mismatch_count = 0;
   int      checked_count = 0;
   int      short_count = 0;
   int      long_count = 0;
   int      undefined_count = 0;
   bit      gaps_enabled = 1'b1;

   multiply_accumulate_long_unit_core dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

   always #5 clock = ~clock;

   // expected result of one multiply request
   function automatic rsp_type predict_product(req_type r);
      logic [63:0] wide_m;
      logic [63:0] wide_s;
      logic [63:0] wide_sum;
      logic [31:0] short_sum;
      rsp_type     res;
      res = '0;
      if (r.long_form) begin
         if (r.signed_form) begin
            wide_m = {{32{r.operand_m[31]}}, r.operand_m};
            wide_s = {{32{r.operand_s[31]}}, r.operand_s};
         end else begin
            wide_m = {32'd0, r.operand_m};
            wide_s = {32'd0, r.operand_s};
         end
         // low 64 bits of the product are the same for the signed case
         wide_sum = wide_m * wide_s;
         if (r.accumulate)
            wide_sum = wide_sum + {r.acc_high, r.acc_low};
         res.result_low   = wide_sum[31:0];
         res.result_high  = wide_sum[63:32];
         res.high_written = 1'b1;
         if (r.set_flags) begin
            res.flags_update  = 1'b1;
            res.negative_flag = wide_sum[63];
            res.zero_flag     = (wide_sum == 64'd0);
         end
      end else if (r.signed_form) begin
         // short signed encoding: nothing is written
         res.undefined = 1'b1;
      end else begin
         short_sum = r.operand_m * r.operand_s;
         if (r.accumulate)
            short_sum = short_sum + r.acc_low;
         res.result_low = short_sum;
         if (r.set_flags) begin
            res.flags_update  = 1'b1;
            res.negative_flag = short_sum[31];
            res.zero_flag     = (short_sum == 32'd0);
         end
      end
      return res;
   endfunction

   function automatic req_type make_request(logic [31:0] m, logic [31:0] s,
                                            logic [31:0] ah, logic [31:0] al,
                                            logic lf, logic sf, logic ac, logic fl);
      req_type r;
      r.operand_m   = m;
      r.operand_s   = s;
      r.acc_high    = ah;
      r.acc_low     = al;
      r.long_form   = lf;
      r.signed_form = sf;
      r.accumulate  = ac;
      r.set_flags   = fl;
      return r;
   endfunction

   // operand values biased toward the corners
   function automatic logic [31:0] pick_operand();
      case ($urandom_range(0, 7))
         0: return 32'd0;
         1: return ALL_ONES;
         2: return MOST_NEG;
         3: return MOST_POS;
         4: return $urandom_range(0, 15);
         default: return $urandom();
      endcase
   endfunction

   task automatic compare_field(string field_name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         if (mismatch_count < 10)
            $display("%0t: %s mismatch, expected %h, actual %h",
                     $realtime, field_name, want, got);
         mismatch_count++;
      end
   endtask

   // track accepted requests and check each result against the oldest prediction
   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset) begin
         if (start && !busy) begin
            pending_products.push_back(predict_product(req_payload));
            if (req_payload.long_form)
               long_count++;
            else if (req_payload.signed_form)
               undefined_count++;
            else
               short_count++;
         end
         if (rsp_strobe) begin
            if (pending_products.size() == 0) begin
               if (mismatch_count < 10)
                  $display("%0t: result with no request outstanding", $realtime);
               mismatch_count++;
            end else begin
               want = pending_products.pop_front();
               compare_field("result_low", want.result_low, rsp_payload.result_low);
               compare_field("result_high", want.result_high, rsp_payload.result_high);
               compare_field("high_written", 32'(want.high_written),
                             32'(rsp_payload.high_written));
               compare_field("negative_flag", 32'(want.negative_flag),
                             32'(rsp_payload.negative_flag));
               compare_field("zero_flag", 32'(want.zero_flag),
                             32'(rsp_payload.zero_flag));
               compare_field("flags_update", 32'(want.flags_update),
                             32'(rsp_payload.flags_update));
               compare_field("undefined", 32'(want.undefined),
                             32'(rsp_payload.undefined));
               checked_count++;
            end
         end
      end
   end

   // present one request, with an occasional gap before it, until it is taken
   task automatic send_request(req_type r);
      if (gaps_enabled && $urandom_range(0, 99) < 5) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      start       <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (busy);
   endtask

   // hold off new requests until every outstanding result has arrived
   task automatic wait_for_results();
      int waited;
      waited = 0;
      start <= 1'b0;
      // let the last accepted request reach the queue
      @(posedge clock);
      while (pending_products.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
   endtask

   task automatic test_short_form();
      // zero product, all-ones squared, wrap to zero, sign bit, ignored high word
      send_request(make_request(32'd0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0, 1'b0, 1'b1));
      send_request(make_request(ALL_ONES, ALL_ONES, 32'd0, 32'd0, 1'b0, 1'b0, 1'b0, 1'b1));
      send_request(make_request(32'd1, 32'd1, 32'd0, ALL_ONES, 1'b0, 1'b0, 1'b1, 1'b1));
      send_request(make_request(MOST_NEG, 32'd1, 32'd0, 32'd0, 1'b0, 1'b0, 1'b0, 1'b1));
      send_request(make_request(MOST_POS, 32'd3, ALL_ONES, 32'd5, 1'b0, 1'b0, 1'b1, 1'b0));
   endtask

   task automatic test_long_unsigned();
      send_request(make_request(ALL_ONES, ALL_ONES, 32'd0, 32'd0, 1'b1, 1'b0, 1'b0, 1'b1));
      send_request(make_request(32'd0, ALL_ONES, 32'd0, 32'd0, 1'b1, 1'b0, 1'b0, 1'b1));
      // 64-bit accumulate wraps to zero
      send_request(make_request(32'd1, 32'd1, ALL_ONES, ALL_ONES, 1'b1, 1'b0, 1'b1, 1'b1));
      send_request(make_request(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, 1'b1, 1'b0, 1'b1, 1'b0));
      send_request(make_request(MOST_NEG, 32'd2, 32'd0, 32'd0, 1'b1, 1'b0, 1'b0, 1'b1));
   endtask

   task automatic test_long_signed();
      send_request(make_request(MOST_NEG, MOST_NEG, 32'd0, 32'd0, 1'b1, 1'b1, 1'b0, 1'b1));
      send_request(make_request(MOST_NEG, MOST_POS, 32'd0, 32'd0, 1'b1, 1'b1, 1'b0, 1'b1));
      send_request(make_request(ALL_ONES, 32'd1, 32'd0, 32'd0, 1'b1, 1'b1, 1'b0, 1'b1));
      send_request(make_request(ALL_ONES, ALL_ONES, 32'd0, 32'd0, 1'b1, 1'b1, 1'b0, 1'b1));
      // minus one plus one gives zero
      send_request(make_request(ALL_ONES, 32'd1, 32'd0, 32'd1, 1'b1, 1'b1, 1'b1, 1'b1));
   endtask

   task automatic test_undefined_encoding();
      int i;
      for (i = 0; i < 4; i++)
         send_request(make_request($urandom(), $urandom(), $urandom(), $urandom(),
                                   1'b0, 1'b1, i[0], i[1]));
   endtask

   task automatic test_random_items(int count);
      req_type r;
      int      i;
      for (i = 0; i < count; i++) begin
         r = make_request(pick_operand(), pick_operand(), pick_operand(), pick_operand(),
                          ($urandom_range(0, 9) < 6), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         send_request(r);
      end
   endtask

   task automatic test_sender_pause();
      test_random_items(20);
      wait_for_results();
      test_random_items(20);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_short_form();
      test_long_unsigned();
      test_long_signed();
      test_undefined_encoding();

      gaps_enabled = 1'b1;
      test_random_items(660);
      test_sender_pause();
      gaps_enabled = 1'b0;
      test_random_items(400);
      gaps_enabled = 1'b1;
      test_random_items(500);

      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (pending_products.size() != 0) begin
         $display("%0d results never arrived", pending_products.size());
         mismatch_count += pending_products.size();
      end
      $display("checked %0d results: %0d short, %0d long, %0d undefined encodings",
               checked_count, short_count, long_count, undefined_count);
      $display("sender ran with random gaps, back to back, and one full pause; %0d mismatches",
               mismatch_count);
      if (mismatch_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   // run limit
   initial begin
      #2_000_000;
      $display("run did not finish in time");
      $display("CHECK FAILED");
      $finish;
   end

endmodule
